@@ rtl/msa_pkg.sv @@
// Shared constants, types and helpers for the message slot allocator.
package msa_pkg;

	localparam int POOL_SLOTS  = 32;
	localparam int CACHE_DEPTH = 8;

	localparam int SLOT_W = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
	localparam int CNT_W  = $clog2(CACHE_DEPTH + 1);
	localparam int CIDX_W = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;

	localparam int SLOT_IN_W  = 6;
	localparam int SLOT_OUT_W = 5;
	localparam int STATUS_W   = 3;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [STATUS_W-1:0] STS_FROM_CACHE = 3'd0;
	localparam logic [STATUS_W-1:0] STS_FROM_POOL  = 3'd1;
	localparam logic [STATUS_W-1:0] STS_EXHAUSTED  = 3'd2;
	localparam logic [STATUS_W-1:0] STS_TO_CACHE   = 3'd3;
	localparam logic [STATUS_W-1:0] STS_TO_POOL    = 3'd4;
	localparam logic [STATUS_W-1:0] STS_INVALID    = 3'd5;

	typedef struct packed {
		logic              scan_start;
		logic              scan_step;
		logic              clr;
		logic              set;
		logic [SLOT_W-1:0] idx;
	} pool_cmd_t;

	typedef struct packed {
		logic              hit;
		logic              last;
		logic [SLOT_W-1:0] ptr;
	} pool_sts_t;

	function automatic logic [SLOT_OUT_W-1:0] to_slot_out(input logic [SLOT_W-1:0] idx);
		logic [SLOT_W+SLOT_OUT_W-1:0] wide;
		wide = (SLOT_W + SLOT_OUT_W)'(idx);
		return wide[SLOT_OUT_W-1:0];
	endfunction

endpackage

@@ rtl/msa_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module msa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/msa_pool.sv @@
// Pool free bits and the scan pointer that tests one slot per cycle.
module msa_pool (
	input  logic               clk,
	input  logic               arst_n,
	input  msa_pkg::pool_cmd_t cmd,
	output msa_pkg::pool_sts_t sts
);

	import msa_pkg::*;

	logic [POOL_SLOTS-1:0] free_q;
	logic [SLOT_W-1:0]     ptr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q <= '1;
			ptr_q  <= '0;
		end else begin
			if (cmd.clr) begin
				free_q[cmd.idx] <= 1'b0;
			end else if (cmd.set) begin
				free_q[cmd.idx] <= 1'b1;
			end
			if (cmd.scan_start) begin
				ptr_q <= '0;
			end else if (cmd.scan_step) begin
				ptr_q <= ptr_q + 1'b1;
			end
		end
	end

	assign sts.hit  = free_q[ptr_q];
	assign sts.last = (ptr_q == SLOT_W'(POOL_SLOTS - 1));
	assign sts.ptr  = ptr_q;

endmodule

@@ rtl/message_slot_allocator_top.sv @@
// Message slot allocator: LIFO cache of freed slots in front of a scanned pool of free bits.
// in_stall is high while a request is in progress. A free request goes straight to the output
// state, an allocation served from the cache first passes the pop state (the cache RAM has a
// registered read), and an allocation from the pool scans from slot 0 up to the first free slot,
// or over all POOL_SLOTS slots when the pool is exhausted, testing one free bit per cycle. The
// result then moves into the output register, and the next transfer is taken while it waits there.
module message_slot_allocator_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           op,
	input  logic [msa_pkg::SLOT_IN_W-1:0]  slot_in,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [msa_pkg::SLOT_OUT_W-1:0] slot_out,
	output logic [msa_pkg::STATUS_W-1:0]   status
);

	import msa_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_POP  = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;
	localparam logic [1:0] S_OUT  = 2'd3;

	logic [1:0]            state_q, state_d;
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      count_m1;
	logic                  out_valid_q;
	logic [SLOT_OUT_W-1:0] res_slot_q, res_slot_d, slot_out_q;
	logic [STATUS_W-1:0]   res_status_q, res_status_d, status_q;
	logic                  res_load;
	logic                  out_load;
	logic                  accept;
	logic                  is_free;
	logic                  idx_ok;
	logic                  cache_empty;
	logic                  cache_full;
	logic                  push;
	logic [SLOT_W-1:0]     ram_rdata;
	pool_cmd_t             pcmd;
	pool_sts_t             psts;

	assign in_stall    = (state_q != S_IDLE);
	assign accept      = in_valid && !in_stall;
	assign is_free     = (op == OP_FREE);
	assign idx_ok      = ({1'b0, slot_in} < 7'(POOL_SLOTS));
	assign cache_empty = (count_q == '0);
	assign cache_full  = (count_q == CNT_W'(CACHE_DEPTH));
	assign count_m1    = count_q - 1'b1;
	assign push        = accept && is_free && idx_ok && !cache_full;
	assign out_load    = (state_q == S_OUT) && (!out_valid_q || !out_stall);

	msa_ram #(
		.WIDTH(SLOT_W),
		.DEPTH(CACHE_DEPTH)
	) u_cache (
		.clk  (clk),
		.we   (push),
		.waddr(count_q[CIDX_W-1:0]),
		.wdata(SLOT_W'(slot_in)),
		.raddr(count_m1[CIDX_W-1:0]),
		.rdata(ram_rdata)
	);

	always_comb begin
		pcmd.scan_start = accept && !is_free && cache_empty;
		pcmd.scan_step  = (state_q == S_SCAN) && !psts.hit && !psts.last;
		pcmd.clr        = push || ((state_q == S_SCAN) && psts.hit);
		pcmd.set        = accept && is_free && idx_ok && cache_full;
		pcmd.idx        = (state_q == S_SCAN) ? psts.ptr : SLOT_W'(slot_in);
	end

	msa_pool u_pool (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (pcmd),
		.sts   (psts)
	);

	always_comb begin
		state_d      = state_q;
		res_load     = 1'b0;
		res_slot_d   = '0;
		res_status_d = STS_INVALID;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (is_free) begin
						state_d  = S_OUT;
						res_load = 1'b1;
						if (!idx_ok) begin
							res_status_d = STS_INVALID;
						end else if (!cache_full) begin
							res_slot_d   = slot_in[SLOT_OUT_W-1:0];
							res_status_d = STS_TO_CACHE;
						end else begin
							res_slot_d   = slot_in[SLOT_OUT_W-1:0];
							res_status_d = STS_TO_POOL;
						end
					end else if (cache_empty) begin
						state_d = S_SCAN;
					end else begin
						state_d = S_POP;
					end
				end
			end
			S_POP: begin
				state_d      = S_OUT;
				res_load     = 1'b1;
				res_slot_d   = to_slot_out(ram_rdata);
				res_status_d = STS_FROM_CACHE;
			end
			S_SCAN: begin
				if (psts.hit) begin
					state_d      = S_OUT;
					res_load     = 1'b1;
					res_slot_d   = to_slot_out(psts.ptr);
					res_status_d = STS_FROM_POOL;
				end else if (psts.last) begin
					state_d      = S_OUT;
					res_load     = 1'b1;
					res_status_d = STS_EXHAUSTED;
				end
			end
			S_OUT: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && !is_free && !cache_empty) begin
				count_q <= count_m1;
			end else if (push) begin
				count_q <= count_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_slot_q   <= res_slot_d;
			res_status_q <= res_status_d;
		end
		if (out_load) begin
			slot_out_q <= res_slot_q;
			status_q   <= res_status_q;
		end
	end

	assign out_valid = out_valid_q;
	assign slot_out  = slot_out_q;
	assign status    = status_q;

endmodule

@@ rtl/msa_checker.sv @@
// Port-level assertions for the message slot allocator and the bind that attaches them.
module msa_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_stall,
	input logic                           op,
	input logic [msa_pkg::SLOT_IN_W-1:0]  slot_in,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic [msa_pkg::SLOT_OUT_W-1:0] slot_out,
	input logic [msa_pkg::STATUS_W-1:0]   status
);

	import msa_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(slot_out) && $stable(status))
		else $error("Stalled result transfer changed.");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("Block took a second transfer before finishing the first.");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == STS_EXHAUSTED || status == STS_INVALID) |-> slot_out == '0)
		else $error("Failed request returned a nonzero slot.");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == STS_FROM_POOL || status == STS_FROM_CACHE ||
			status == STS_TO_CACHE || status == STS_TO_POOL)
		|-> 7'(slot_out) < 7'(POOL_SLOTS))
		else $error("Returned slot lies outside the pool.");

endmodule

bind message_slot_allocator_top msa_checker u_msa_checker (.*);
